// File: hdl/lsac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared constants, types and helpers of the letterbox scaler / compositor.
// ----------------------------------------------------------------------------
package lsac_pkg;

    localparam int MAX_SRC_W   = 256;
    localparam int MAX_SRC_H   = 256;
    localparam int MAX_DST_DIM = 1024;

    // fixed field widths
    localparam int SW_W   = 9;
    localparam int DW_W   = 11;
    localparam int CRD_W  = 10;
    localparam int PIX_W  = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 32;

    // store geometry
    localparam int CXW    = $clog2(MAX_SRC_W);
    localparam int CYW    = $clog2(MAX_SRC_H);
    localparam int AW     = CXW + CYW;

    // per-item divider: numerator is offset coordinate times source size
    localparam int QW     = CXW > CYW ? CXW : CYW;
    localparam int NUM_W  = CRD_W + SW_W;

    // fit divider: numerator is destination size times source size
    localparam int FNUM_W = DW_W + SW_W;
    localparam int FCNT_W = $clog2(FNUM_W + 1);

    // register indexes
    localparam logic [IDX_W-1:0] REG_SRC_W  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_W  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_H  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BG     = 3'd4;

    localparam logic [7:0]       ALPHA_FULL = 8'hff;
    localparam logic [16:0]      RECIP_255  = 17'h08081;

    typedef enum logic [1:0] {
        FIT_IDLE,
        FIT_SETUP,
        FIT_DIV,
        FIT_FIN
    } fit_state_t;

    // effective geometry handed to the render pipeline
    typedef struct packed {
        logic [SW_W-1:0]  sw;
        logic [SW_W-1:0]  sh;
        logic [DW_W-1:0]  dw;
        logic [DW_W-1:0]  dh;
        logic [DW_W-1:0]  fw;
        logic [DW_W-1:0]  fh;
        logic [CRD_W-1:0] ox;
        logic [CRD_W-1:0] oy;
        logic [PIX_W-1:0] bg;
    } geom_t;

    // item as it travels through the divider stages
    typedef struct packed {
        logic             vld;
        logic             req;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [PIX_W-1:0] pix;
        logic             oob;
        logic             in_box;
        logic             ld_ok;
        logic [NUM_W-1:0] rx;
        logic [NUM_W-1:0] ry;
        logic [QW-1:0]    qx;
        logic [QW-1:0]    qy;
    } div_t;

    function automatic logic [SW_W-1:0] clamp_src(input logic [SW_W-1:0] v,
                                                  input int hi);
        logic [SW_W-1:0] r;
        r = v;
        if (v == '0)
            r = SW_W'(1);
        else if (32'(v) > hi)
            r = SW_W'(hi);
        return r;
    endfunction

    function automatic logic [DW_W-1:0] clamp_dst(input logic [DW_W-1:0] v);
        logic [DW_W-1:0] r;
        r = v;
        if (v == '0)
            r = DW_W'(1);
        else if (32'(v) > MAX_DST_DIM)
            r = DW_W'(MAX_DST_DIM);
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/lsac_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_req_if
// Request channel: load or render item with valid / ready handshake.
// ----------------------------------------------------------------------------
interface lsac_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [lsac_pkg::CRD_W-1:0] coord_x;
    logic [lsac_pkg::CRD_W-1:0] coord_y;
    logic [lsac_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, req_type, coord_x, coord_y, pixel_in, input ready);
    modport sink   (input valid, req_type, coord_x, coord_y, pixel_in, output ready);
endinterface
`default_nettype wire

// File: hdl/lsac_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_rsp_if
// Result channel: rendered pixel and coordinate error flag.
// ----------------------------------------------------------------------------
interface lsac_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [lsac_pkg::PIX_W-1:0] pixel_out;
    logic                       coord_error;

    modport source (output valid, pixel_out, coord_error, input ready);
    modport sink   (input valid, pixel_out, coord_error, output ready);
endinterface
`default_nettype wire

// File: hdl/lsac_fit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_fit
// Configuration registers and the sequencer that recomputes the fitted
// area and its centring offsets with a bit-serial divider.
// ----------------------------------------------------------------------------
module lsac_fit
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [lsac_pkg::IDX_W-1:0] cfg_idx,
    input  wire logic [lsac_pkg::CFG_W-1:0] cfg_data,
    output lsac_pkg::geom_t                 geom,
    output logic                            busy
);
    import lsac_pkg::*;

    logic [SW_W-1:0]   sw_raw_reg, sh_raw_reg;
    logic [DW_W-1:0]   dw_raw_reg, dh_raw_reg;
    logic [PIX_W-1:0]  bg_reg;
    logic [DW_W-1:0]   fw_reg, fh_reg;
    logic [CRD_W-1:0]  ox_reg, oy_reg;
    fit_state_t        state_reg, state_next;
    logic              wide_reg;
    logic [FNUM_W-1:0] num_reg;
    logic [SW_W-1:0]   den_reg;
    logic [FNUM_W-1:0] quo_reg;
    logic [SW_W:0]     rem_reg;
    logic [FCNT_W-1:0] cnt_reg;

    logic [SW_W-1:0]   sw, sh;
    logic [DW_W-1:0]   dw, dh;
    logic [FNUM_W-1:0] prod_a, prod_b;
    logic [SW_W:0]     rem_shift;
    logic              rem_ge;
    logic [DW_W-1:0]   quo_cl;
    logic              div_last;

    assign sw = clamp_src(sw_raw_reg, MAX_SRC_W);
    assign sh = clamp_src(sh_raw_reg, MAX_SRC_H);
    assign dw = clamp_dst(dw_raw_reg);
    assign dh = clamp_dst(dh_raw_reg);

    // cross products for the aspect compare
    assign prod_a = FNUM_W'(sw) * FNUM_W'(dh);
    assign prod_b = FNUM_W'(sh) * FNUM_W'(dw);

    // one restoring division step
    assign rem_shift = {rem_reg[SW_W-1:0], num_reg[FNUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign div_last  = cnt_reg == FCNT_W'(FNUM_W - 1);

    // quotient clamped to at least one
    assign quo_cl = (quo_reg == '0) ? DW_W'(1) : quo_reg[DW_W-1:0];

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_raw_reg <= SW_W'(256);
            sh_raw_reg <= SW_W'(256);
            dw_raw_reg <= DW_W'(256);
            dh_raw_reg <= DW_W'(256);
            bg_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SRC_W: sw_raw_reg <= cfg_data[SW_W-1:0];
                REG_SRC_H: sh_raw_reg <= cfg_data[SW_W-1:0];
                REG_DST_W: dw_raw_reg <= cfg_data[DW_W-1:0];
                REG_DST_H: dh_raw_reg <= cfg_data[DW_W-1:0];
                REG_BG:    bg_reg     <= cfg_data[PIX_W-1:0];
                default:   ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FIT_IDLE:  state_next = FIT_IDLE;
            FIT_SETUP: state_next = FIT_DIV;
            FIT_DIV:   state_next = div_last ? FIT_FIN : FIT_DIV;
            FIT_FIN:   state_next = FIT_IDLE;
            default:   state_next = FIT_IDLE;
        endcase
        if (cfg_we)
            state_next = FIT_SETUP;
    end

    // outputs
    always_comb
    begin
        case (state_reg)
            FIT_IDLE: busy = 1'b0;
            default:  busy = 1'b1;
        endcase
        busy = busy | cfg_we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FIT_IDLE;
        else
            state_reg <= state_next;
    end

    // divider and fit results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= DW_W'(256);
            fh_reg   <= DW_W'(256);
            ox_reg   <= '0;
            oy_reg   <= '0;
            wide_reg <= 1'b0;
            num_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                FIT_SETUP:
                begin
                    wide_reg <= prod_a >= prod_b;
                    num_reg  <= (prod_a >= prod_b) ? FNUM_W'(dw) * FNUM_W'(sh)
                                                   : FNUM_W'(dh) * FNUM_W'(sw);
                    den_reg  <= (prod_a >= prod_b) ? sw : sh;
                    quo_reg  <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                end
                FIT_DIV:
                begin
                    rem_reg <= rem_ge ? rem_shift - {1'b0, den_reg} : rem_shift;
                    quo_reg <= {quo_reg[FNUM_W-2:0], rem_ge};
                    num_reg <= {num_reg[FNUM_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + FCNT_W'(1);
                end
                FIT_FIN:
                begin
                    if (wide_reg)
                    begin
                        fw_reg <= dw;
                        fh_reg <= quo_cl;
                        ox_reg <= '0;
                        oy_reg <= CRD_W'((dh - quo_cl) >> 1);
                    end
                    else
                    begin
                        fw_reg <= quo_cl;
                        fh_reg <= dh;
                        ox_reg <= CRD_W'((dw - quo_cl) >> 1);
                        oy_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign geom.sw = sw;
    assign geom.sh = sh;
    assign geom.dw = dw;
    assign geom.dh = dh;
    assign geom.fw = fw_reg;
    assign geom.fh = fh_reg;
    assign geom.ox = ox_reg;
    assign geom.oy = oy_reg;
    assign geom.bg = bg_reg;

endmodule
`default_nettype wire

// File: hdl/lsac_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_pipe
// Render pipeline: classify, scale multiply, pipelined sample divider,
// frame store, blend products, divide by 255 and output register.
// ----------------------------------------------------------------------------
module lsac_pipe
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsac_pkg::geom_t geom,
    input  wire logic            busy,
    lsac_req_if.sink             req,
    lsac_rsp_if.source           rsp
);
    import lsac_pkg::*;

    logic           en;
    logic           out_vld_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic           out_err_reg;

    div_t           dv_reg [QW+1];
    div_t           s1_next;
    logic [CRD_W-1:0] dx, dy;
    logic [DW_W:0]  xend, yend;

    // whole pipeline moves unless the output item is stuck
    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en && !busy;

    // classify and scale
    assign dx   = req.coord_x - geom.ox;
    assign dy   = req.coord_y - geom.oy;
    assign xend = (DW_W+1)'(geom.ox) + (DW_W+1)'(geom.fw);
    assign yend = (DW_W+1)'(geom.oy) + (DW_W+1)'(geom.fh);

    always_comb
    begin
        s1_next.vld    = req.valid && req.ready;
        s1_next.req    = req.req_type;
        s1_next.x      = req.coord_x;
        s1_next.y      = req.coord_y;
        s1_next.pix    = req.pixel_in;
        s1_next.oob    = (DW_W'(req.coord_x) >= geom.dw) ||
                         (DW_W'(req.coord_y) >= geom.dh);
        s1_next.in_box = (req.coord_x >= geom.ox) &&
                         ((DW_W+1)'(req.coord_x) < xend) &&
                         (req.coord_y >= geom.oy) &&
                         ((DW_W+1)'(req.coord_y) < yend);
        s1_next.ld_ok  = (SW_W'(req.coord_x) < geom.sw) &&
                         (SW_W'(req.coord_y) < geom.sh) &&
                         (req.coord_x < CRD_W'(MAX_SRC_W)) &&
                         (req.coord_y < CRD_W'(MAX_SRC_H));
        s1_next.rx     = NUM_W'(dx) * NUM_W'(geom.sw);
        s1_next.ry     = NUM_W'(dy) * NUM_W'(geom.sh);
        s1_next.qx     = '0;
        s1_next.qy     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= '0;
        else if (en)
            dv_reg[0] <= s1_next;
    end

    // divider stages, one quotient bit each
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = QW - 1 - k;
        div_t           st_next;
        logic [NUM_W:0] tx, ty;

        assign tx = (NUM_W+1)'(geom.fw) << B;
        assign ty = (NUM_W+1)'(geom.fh) << B;

        always_comb
        begin
            st_next = dv_reg[k];
            if ({1'b0, dv_reg[k].rx} >= tx)
            begin
                st_next.rx    = dv_reg[k].rx - tx[NUM_W-1:0];
                st_next.qx[B] = 1'b1;
            end
            if ({1'b0, dv_reg[k].ry} >= ty)
            begin
                st_next.ry    = dv_reg[k].ry - ty[NUM_W-1:0];
                st_next.qy[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= '0;
            else if (en)
                dv_reg[k+1] <= st_next;
        end
    end

    // frame store, loads and renders share one port at the same stage
    logic [PIX_W-1:0] mem [2**AW];
    logic [PIX_W-1:0] rd_reg;
    logic [AW-1:0]    addr;
    logic             m_vld_reg, m_oob_reg, m_in_reg;
    div_t             dq;

    assign dq   = dv_reg[QW];
    assign addr = dq.req ? {dq.qy[CYW-1:0], dq.qx[CXW-1:0]}
                         : {dq.y[CYW-1:0], dq.x[CXW-1:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dq.vld && !dq.req && dq.ld_ok)
                mem[addr] <= dq.pix;
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            m_oob_reg <= 1'b0;
            m_in_reg  <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= dq.vld && dq.req;
            m_oob_reg <= dq.oob;
            m_in_reg  <= dq.in_box;
        end
    end

    // blend products per channel
    logic [16:0]      sum_reg [3];
    logic [PIX_W-1:0] b_pix_reg;
    logic             b_vld_reg, b_oob_reg, b_in_reg;
    logic [7:0]       alpha;

    assign alpha = rd_reg[31:24];

    for (genvar c = 0; c < 3; c++)
    begin : g_mul
        logic [15:0] ps, pg;
        assign ps = 16'(rd_reg[8*c +: 8]) * 16'(alpha);
        assign pg = 16'(geom.bg[8*c +: 8]) * 16'(ALPHA_FULL - alpha);

        always_ff @(posedge clk)
        begin
            if (en)
                sum_reg[c] <= 17'(ps) + 17'(pg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            b_oob_reg <= 1'b0;
            b_in_reg  <= 1'b0;
            b_pix_reg <= '0;
        end
        else if (en)
        begin
            b_vld_reg <= m_vld_reg;
            b_oob_reg <= m_oob_reg;
            b_in_reg  <= m_in_reg;
            b_pix_reg <= rd_reg;
        end
    end

    // divide by 255 through the reciprocal, select the final pixel
    logic [PIX_W-1:0] mix;
    logic [PIX_W-1:0] out_pix_next;

    for (genvar c = 0; c < 3; c++)
    begin : g_div255
        logic [33:0] pr;
        assign pr = 34'(sum_reg[c]) * 34'(RECIP_255);
        assign mix[8*c +: 8] = pr[30:23];
    end
    assign mix[31:24] = ALPHA_FULL;

    always_comb
    begin
        if (b_oob_reg || !b_in_reg)
            out_pix_next = geom.bg;
        else if (b_pix_reg[31:24] == ALPHA_FULL)
            out_pix_next = b_pix_reg;
        else
            out_pix_next = mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            out_err_reg <= 1'b0;
            out_pix_reg <= '0;
        end
        else if (en)
        begin
            out_vld_reg <= b_vld_reg;
            out_err_reg <= b_oob_reg;
            out_pix_reg <= out_pix_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.pixel_out   = out_pix_reg;
    assign rsp.coord_error = out_err_reg;

endmodule
`default_nettype wire

// File: hdl/letterbox_scale_alpha_composite.sv
`timescale 1ns / 1ps
`default_nettype none
// path: a render item passes the classify register, the divider stages, the frame
// store read, the blend register and the output register; stalls hold it there.
// throughput: one item per cycle while the output is not stalled and no refit runs
// a configuration write starts a refit (setup, bit-serial fit divider, finish), and no item is accepted until it ends
// reset: registers return to 256x256 source, 256x256 box, black background;
// the frame store is not cleared
// ----------------------------------------------------------------------------
// letterbox_scale_alpha_composite
// Nearest-neighbour letterbox scaler with alpha blend over a background.
// ----------------------------------------------------------------------------
module letterbox_scale_alpha_composite
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    lsac_req_if.sink                        req,
    lsac_rsp_if.source                      rsp,
    input  wire logic                       cfg_we,
    input  wire logic [lsac_pkg::IDX_W-1:0] cfg_idx,
    input  wire logic [lsac_pkg::CFG_W-1:0] cfg_data
);
    import lsac_pkg::*;

    geom_t geom;
    logic  busy;

    // configuration and fit sequencer
    lsac_fit u_fit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .geom     (geom),
        .busy     (busy)
    );

    // render pipeline
    lsac_pipe u_pipe
    (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .busy  (busy),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

// File: verif/letterbox_scale_alpha_composite_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letterbox_scale_alpha_composite_tb
// Loads source pixels and renders destination pixels through the letterbox
// scaler under several geometries and background colors. Expected pixels
// come from a local fit / sample / blend predictor and are compared in order.
// ----------------------------------------------------------------------------
module letterbox_scale_alpha_composite_tb;
    import lsac_pkg::*;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [PIX_W-1:0] pix;
    } work_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             err;
    } pixel_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    lsac_req_if req_ch ();
    lsac_rsp_if rsp_ch ();

    letterbox_scale_alpha_composite i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic [PIX_W-1:0] frame_mem [int];
    int unsigned src_w, src_h, dst_w, dst_h, fit_w, fit_h, off_x, off_y;
    logic [PIX_W-1:0] bg;

    work_item_t    pending_items [$];
    pixel_result_t expected_pixels [$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void refit();
        longint unsigned sw, sh, dw, dh, fw, fh;
        sw = clip(src_w, MAX_SRC_W);
        sh = clip(src_h, MAX_SRC_H);
        dw = clip(dst_w, MAX_DST_DIM);
        dh = clip(dst_h, MAX_DST_DIM);
        if (sw * dh >= sh * dw)
        begin
            fw = dw;
            fh = dw * sh / sw;
        end
        else
        begin
            fh = dh;
            fw = dh * sw / sh;
        end
        if (fw < 1)
            fw = 1;
        if (fh < 1)
            fh = 1;
        fit_w = 32'(fw);
        fit_h = 32'(fh);
        off_x = 32'((dw - fw) / 2);
        off_y = 32'((dh - fh) / 2);
    endfunction

    function automatic logic [7:0] mix(logic [7:0] s, logic [7:0] g, logic [7:0] a);
        int unsigned t;
        t = (s * a + g * (255 - a)) / 255;
        return t[7:0];
    endfunction

    // predicts one item, pushing the rendered pixel if any
    function automatic void predict_pixel(work_item_t it);
        int unsigned sw, sh, sx, sy;
        logic [PIX_W-1:0] p;
        pixel_result_t r;
        sw = clip(src_w, MAX_SRC_W);
        sh = clip(src_h, MAX_SRC_H);
        if (it.req_type == REQ_LOAD)
        begin
            if (it.x < sw && it.y < sh)
                frame_mem[it.y * MAX_SRC_W + it.x] = it.pix;
            return;
        end
        r.err = 1'b0;
        r.pix = bg;
        if (it.x >= clip(dst_w, MAX_DST_DIM) || it.y >= clip(dst_h, MAX_DST_DIM))
            r.err = 1'b1;
        else if (!(it.x < off_x || it.x >= off_x + fit_w
                   || it.y < off_y || it.y >= off_y + fit_h))
        begin
            sx = (it.x - off_x) * sw / fit_w;
            sy = (it.y - off_y) * sh / fit_h;
            p = frame_mem.exists(sy * MAX_SRC_W + sx) ? frame_mem[sy * MAX_SRC_W + sx] : '0;
            if (p[31:24] == ALPHA_FULL)
                r.pix = p;
            else
                r.pix = {8'hff, mix(p[23:16], bg[23:16], p[31:24]),
                         mix(p[15:8], bg[15:8], p[31:24]), mix(p[7:0], bg[7:0], p[31:24])};
        end
        expected_pixels.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                work_item_t it;
                it = pending_items.pop_front();
                predict_pixel(it);
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= it.req_type;
                req_ch.coord_x  <= it.x;
                req_ch.coord_y  <= it.y;
                req_ch.pixel_in <= it.pix;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected item", rsp_ch.pixel_out, '0);
                else
                begin
                    pixel_result_t w;
                    w = expected_pixels.pop_front();
                    if (rsp_ch.pixel_out !== w.pix)
                        report_mismatch("pixel_out", rsp_ch.pixel_out, w.pix);
                    if (rsp_ch.coord_error !== w.err)
                        report_mismatch("coord_error", PIX_W'(rsp_ch.coord_error),
                                        PIX_W'(w.err));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || req_ch.valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SRC_W: src_w = val[8:0];
            REG_SRC_H: src_h = val[8:0];
            REG_DST_W: dst_w = val[10:0];
            REG_DST_H: dst_h = val[10:0];
            REG_BG:    bg = val;
            default: ;
        endcase
        refit();
        repeat (40) @(posedge clk);
    endtask

    function automatic void add_item(logic t, int unsigned x, int unsigned y, logic [31:0] p);
        work_item_t it;
        it.req_type = t;
        it.x = CRD_W'(x);
        it.y = CRD_W'(y);
        it.pix = p;
        pending_items.push_back(it);
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(3))
            0: return {8'hff, 24'($urandom)};
            1: return {8'h00, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // fills every source pixel of the current size, so renders read written entries
    function automatic void fill_source();
        for (int y = 0; y < clip(src_h, MAX_SRC_H); y++)
            for (int x = 0; x < clip(src_w, MAX_SRC_W); x++)
                add_item(REQ_LOAD, x, y, rand_pixel());
    endfunction

    function automatic void random_renders(int n);
        int unsigned dw, dh;
        dw = clip(dst_w, MAX_DST_DIM);
        dh = clip(dst_h, MAX_DST_DIM);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                add_item(REQ_RENDER, $urandom_range(1023), $urandom_range(1023), $urandom);
            else if ($urandom_range(9) == 0)
                // load outside the source, ignored
                add_item(REQ_LOAD, $urandom_range(1023, 256), $urandom_range(1023),
                         $urandom);
            else
                add_item(REQ_RENDER, $urandom_range(dw - 1), $urandom_range(dh - 1),
                         $urandom);
        end
    endfunction

    // one phase: geometry, background, full source load, renders
    task automatic phase(int sw, int sh, int dw, int dh, logic [31:0] b, int n);
        write_reg(REG_SRC_W, sw);
        write_reg(REG_SRC_H, sh);
        write_reg(REG_DST_W, dw);
        write_reg(REG_DST_H, dh);
        write_reg(REG_BG, b);
        fill_source();
        random_renders(n);
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 36;
        recv_idle_pct = 86;
        src_w = 256;
        src_h = 256;
        dst_w = 256;
        dst_h = 256;
        bg = '0;
        refit();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.coord_x = '0;
        req_ch.coord_y = '0;
        req_ch.pixel_in = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (40) @(posedge clk);

        // directed: 2x2 source into 4x8 box, extremes and letterbox edges
        write_reg(REG_SRC_W, 2);
        write_reg(REG_SRC_H, 2);
        write_reg(REG_DST_W, 4);
        write_reg(REG_DST_H, 8);
        write_reg(REG_BG, 32'h80_40_c0_20);
        add_item(REQ_LOAD, 0, 0, 32'hff_12_34_56);
        add_item(REQ_LOAD, 1, 0, 32'h00_ff_ff_ff);
        add_item(REQ_LOAD, 0, 1, 32'h7f_ff_00_80);
        add_item(REQ_LOAD, 1, 1, 32'hfe_01_fe_ff);
        add_item(REQ_LOAD, 2, 0, 32'hffffffff);
        add_item(REQ_LOAD, 1023, 1023, 32'hffffffff);
        add_item(REQ_RENDER, 0, 0, 32'hffffffff);
        add_item(REQ_RENDER, 0, 2, 0);
        add_item(REQ_RENDER, 3, 2, 0);
        add_item(REQ_RENDER, 0, 5, 0);
        add_item(REQ_RENDER, 3, 5, 0);
        add_item(REQ_RENDER, 3, 7, 0);
        add_item(REQ_RENDER, 4, 0, 0);
        add_item(REQ_RENDER, 0, 8, 0);
        add_item(REQ_RENDER, 1023, 1023, 0);
        add_item(REQ_RENDER, 2, 6, 0);

        // out of range registers: zero and oversize sizes, ignored index
        phase(0, 0, 0, 0, 32'hffffffff, 10);
        phase(511, 1, 2047, 1024, 32'h0, 20);
        write_reg(3'd7, $urandom);
        phase(1, 3, 1, 1, $urandom, 10);
        phase(3, 5, 7, 1000, $urandom, 50);

        // sender pauses until every expected item has arrived
        drain();
        send_idle_pct = 86;
        recv_idle_pct = 36;
        phase(5, 3, 1024, 17, $urandom, 50);
        phase($urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 40), $urandom_range(1, 40), $urandom, 30);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase($urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 1024), $urandom_range(1, 1024), $urandom, 30);
        phase(4, 4, 1024, 1024, 32'hffffffff, 30);
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule
